// ----- sv/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg - shared types and constants for the AABB frustum cull unit
// Transfer structs, configuration register codes and reset values.
// ----------------------------------------------------------------------------
package afc_pkg;

    // Saturation limit of the per-frame visible tally
    localparam int MAX_CHUNKS = 4096;
    localparam int TALLY_W    = 13;

    // Fixed-point widths
    localparam int COORD_W = 24;                        // Q.8 coordinate
    localparam int COEF_W  = 16;                        // Q4.12 coefficient
    localparam int ROW_W   = 3 * COEF_W;                // packed matrix row
    localparam int OFF_W   = 48;                        // translation term
    localparam int PROD_W  = COORD_W + COEF_W;          // one product
    localparam int CLIP_W  = 50;                        // one clip component

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_W = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_W = 3'd7;

    // Reset values: identity transform
    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'd4096;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'd268435456;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'd17592186044416;
    localparam logic [ROW_W-1:0] ROW_W_RESET = 48'd0;
    localparam logic [OFF_W-1:0] OFF_X_RESET = 48'd0;
    localparam logic [OFF_W-1:0] OFF_Y_RESET = 48'd0;
    localparam logic [OFF_W-1:0] OFF_Z_RESET = 48'd0;
    localparam logic [OFF_W-1:0] OFF_W_RESET = 48'd1048576;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic [31:0]               index_start;
        logic [31:0]               index_count;
        logic [31:0]               vertex_base;
        logic [31:0]               vertex_count;
        logic                      first_chunk;
    } box_t;

    typedef struct packed {
        logic               visible;
        logic [31:0]        out_index_start;
        logic [31:0]        out_index_count;
        logic [31:0]        out_vertex_base;
        logic [31:0]        out_vertex_count;
        logic [TALLY_W-1:0] visible_total;
    } cull_t;

    // Outside flags of one corner against the six planes
    typedef struct packed {
        logic left_out;
        logic right_out;
        logic bottom_out;
        logic top_out;
        logic near_out;
        logic far_out;
    } plane_flags_t;

endpackage

// ----- sv/afc_plane_test.sv -----
// ----------------------------------------------------------------------------
// afc_plane_test - six-plane outside test of one clip-space corner
// D3D depth convention: inside when -w <= x,y <= w and 0 <= z <= w.
// ----------------------------------------------------------------------------
module afc_plane_test (
    input  logic signed [afc_pkg::CLIP_W-1:0] cx,
    input  logic signed [afc_pkg::CLIP_W-1:0] cy,
    input  logic signed [afc_pkg::CLIP_W-1:0] cz,
    input  logic signed [afc_pkg::CLIP_W-1:0] cw,
    output afc_pkg::plane_flags_t             flags
);

    logic signed [afc_pkg::CLIP_W:0] x_plus_w;
    logic signed [afc_pkg::CLIP_W:0] w_minus_x;
    logic signed [afc_pkg::CLIP_W:0] y_plus_w;
    logic signed [afc_pkg::CLIP_W:0] w_minus_y;
    logic signed [afc_pkg::CLIP_W:0] w_minus_z;

    // One extra bit keeps each sum exact; the sign gives the strict compare
    assign x_plus_w  = {cx[afc_pkg::CLIP_W-1], cx} + {cw[afc_pkg::CLIP_W-1], cw};
    assign w_minus_x = {cw[afc_pkg::CLIP_W-1], cw} - {cx[afc_pkg::CLIP_W-1], cx};
    assign y_plus_w  = {cy[afc_pkg::CLIP_W-1], cy} + {cw[afc_pkg::CLIP_W-1], cw};
    assign w_minus_y = {cw[afc_pkg::CLIP_W-1], cw} - {cy[afc_pkg::CLIP_W-1], cy};
    assign w_minus_z = {cw[afc_pkg::CLIP_W-1], cw} - {cz[afc_pkg::CLIP_W-1], cz};

    assign flags.left_out   = x_plus_w[afc_pkg::CLIP_W];
    assign flags.right_out  = w_minus_x[afc_pkg::CLIP_W];
    assign flags.bottom_out = y_plus_w[afc_pkg::CLIP_W];
    assign flags.top_out    = w_minus_y[afc_pkg::CLIP_W];
    assign flags.near_out   = cz[afc_pkg::CLIP_W-1];
    assign flags.far_out    = w_minus_z[afc_pkg::CLIP_W];

endmodule

// ----- sv/aabb_frustum_cull_unit.sv -----
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit - clip-space frustum culling of chunk bounding boxes
// Transforms the eight box corners by the configured view-projection rows,
// tests them against the six frustum planes and keeps a per-frame tally.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------
//  box      | in        | box_valid / box_ready  | box_t: corners, draw range
//  cull     | out       | cull_valid / cull_ready| cull_t: visible, range, tally
//  cfg      | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One box is taken per cycle while box_ready is high; each result passes
//  through the input register, product stage, clip-sum stage and result
//  register in order before it is offered at the output. The 24 coefficient
//  multipliers and the corner sums are each given a stage of their own.
//  Each stage has its own valid bit and advances when the next one is empty
//  or moving, so bubbles close up and a held result stalls only what is
//  behind it. Reset clears the valid bits and the tally and loads the
//  identity transform into the configuration registers.
//
module aabb_frustum_cull_unit (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              box_valid,
    output logic                              box_ready,
    input  afc_pkg::box_t                     box,

    output logic                              cull_valid,
    input  logic                              cull_ready,
    output afc_pkg::cull_t                    cull,

    input  logic                              cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afc_pkg::ROW_W-1:0]         cfg_data
);

    // Draw range and frame marker carried alongside the arithmetic
    typedef struct packed {
        logic [31:0] index_start;
        logic [31:0] index_count;
        logic [31:0] vertex_base;
        logic [31:0] vertex_count;
        logic        first_chunk;
    } range_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [afc_pkg::ROW_W-1:0] row_reg [4];
    logic signed [afc_pkg::OFF_W-1:0] off_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= afc_pkg::ROW_X_RESET;
            row_reg[1] <= afc_pkg::ROW_Y_RESET;
            row_reg[2] <= afc_pkg::ROW_Z_RESET;
            row_reg[3] <= afc_pkg::ROW_W_RESET;
            off_reg[0] <= afc_pkg::OFF_X_RESET;
            off_reg[1] <= afc_pkg::OFF_Y_RESET;
            off_reg[2] <= afc_pkg::OFF_Z_RESET;
            off_reg[3] <= afc_pkg::OFF_W_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afc_pkg::CFG_ROW_X: row_reg[0] <= cfg_data;
                afc_pkg::CFG_ROW_Y: row_reg[1] <= cfg_data;
                afc_pkg::CFG_ROW_Z: row_reg[2] <= cfg_data;
                afc_pkg::CFG_ROW_W: row_reg[3] <= cfg_data;
                afc_pkg::CFG_OFF_X: off_reg[0] <= cfg_data;
                afc_pkg::CFG_OFF_Y: off_reg[1] <= cfg_data;
                afc_pkg::CFG_OFF_Z: off_reg[2] <= cfg_data;
                afc_pkg::CFG_OFF_W: off_reg[3] <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage advances when the one after it is empty
    // or moving on in the same cycle.
    // ------------------------------------------------------------------
    logic in_vld_reg;
    logic prod_vld_reg;
    logic clip_vld_reg;
    logic out_vld_reg;
    logic out_adv;
    logic clip_adv;
    logic prod_adv;
    logic in_adv;

    assign out_adv   = !out_vld_reg || cull_ready;
    assign clip_adv  = !clip_vld_reg || out_adv;
    assign prod_adv  = !prod_vld_reg || clip_adv;
    assign in_adv    = !in_vld_reg || prod_adv;
    assign box_ready = in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            clip_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_adv)
                in_vld_reg <= box_valid;
            if (prod_adv)
                prod_vld_reg <= in_vld_reg;
            if (clip_adv)
                clip_vld_reg <= prod_vld_reg;
            if (out_adv)
                out_vld_reg <= clip_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    afc_pkg::box_t box_reg;

    always_ff @(posedge clk)
    begin
        if (in_adv && box_valid)
            box_reg <= box;
    end

    // ------------------------------------------------------------------
    // Product stage: coefficient times low and high end of each axis.
    // prod[row][axis][0] uses the box minimum, [1] the box maximum.
    // ------------------------------------------------------------------
    logic signed [afc_pkg::COORD_W-1:0] axis_lo [3];
    logic signed [afc_pkg::COORD_W-1:0] axis_hi [3];
    logic signed [afc_pkg::PROD_W-1:0]  prod_next [4][3][2];
    logic signed [afc_pkg::PROD_W-1:0]  prod_reg  [4][3][2];
    range_t                             prod_range_reg;

    assign axis_lo[0] = box_reg.min_x;
    assign axis_lo[1] = box_reg.min_y;
    assign axis_lo[2] = box_reg.min_z;
    assign axis_hi[0] = box_reg.max_x;
    assign axis_hi[1] = box_reg.max_y;
    assign axis_hi[2] = box_reg.max_z;

    for (genvar r = 0; r < 4; r++)
    begin : g_prod_row
        for (genvar a = 0; a < 3; a++)
        begin : g_prod_axis
            logic signed [afc_pkg::COEF_W-1:0] coef;
            logic signed [afc_pkg::PROD_W-1:0] coef_ext;
            logic signed [afc_pkg::PROD_W-1:0] lo_ext;
            logic signed [afc_pkg::PROD_W-1:0] hi_ext;

            assign coef     = row_reg[r][afc_pkg::COEF_W*a +: afc_pkg::COEF_W];
            assign coef_ext = afc_pkg::PROD_W'(coef);
            assign lo_ext   = afc_pkg::PROD_W'(axis_lo[a]);
            assign hi_ext   = afc_pkg::PROD_W'(axis_hi[a]);

            assign prod_next[r][a][0] = coef_ext * lo_ext;
            assign prod_next[r][a][1] = coef_ext * hi_ext;

            always_ff @(posedge clk)
            begin
                if (prod_adv && in_vld_reg)
                begin
                    prod_reg[r][a][0] <= prod_next[r][a][0];
                    prod_reg[r][a][1] <= prod_next[r][a][1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_adv && in_vld_reg)
        begin
            prod_range_reg.index_start  <= box_reg.index_start;
            prod_range_reg.index_count  <= box_reg.index_count;
            prod_range_reg.vertex_base  <= box_reg.vertex_base;
            prod_range_reg.vertex_count <= box_reg.vertex_count;
            prod_range_reg.first_chunk  <= box_reg.first_chunk;
        end
    end

    // ------------------------------------------------------------------
    // Clip-sum stage: offset plus three products per corner and row.
    // Corner c takes the maximum of x, y, z where bits 0, 1, 2 of c are set.
    // ------------------------------------------------------------------
    logic signed [afc_pkg::CLIP_W-1:0] clip_next [8][4];
    logic signed [afc_pkg::CLIP_W-1:0] clip_reg  [8][4];
    range_t                            clip_range_reg;

    for (genvar c = 0; c < 8; c++)
    begin : g_clip_corner
        for (genvar r = 0; r < 4; r++)
        begin : g_clip_row
            assign clip_next[c][r] = afc_pkg::CLIP_W'(off_reg[r])
                                   + afc_pkg::CLIP_W'(prod_reg[r][0][c % 2])
                                   + afc_pkg::CLIP_W'(prod_reg[r][1][(c / 2) % 2])
                                   + afc_pkg::CLIP_W'(prod_reg[r][2][(c / 4) % 2]);

            always_ff @(posedge clk)
            begin
                if (clip_adv && prod_vld_reg)
                    clip_reg[c][r] <= clip_next[c][r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clip_adv && prod_vld_reg)
            clip_range_reg <= prod_range_reg;
    end

    // ------------------------------------------------------------------
    // Plane tests: cull only when all eight corners are outside one plane
    // ------------------------------------------------------------------
    afc_pkg::plane_flags_t corner_flags [8];
    afc_pkg::plane_flags_t all_out;

    for (genvar c = 0; c < 8; c++)
    begin : g_test
        afc_plane_test u_plane_test (
            .cx    (clip_reg[c][0]),
            .cy    (clip_reg[c][1]),
            .cz    (clip_reg[c][2]),
            .cw    (clip_reg[c][3]),
            .flags (corner_flags[c])
        );
    end

    always_comb
    begin
        all_out = '1;
        for (int c = 0; c < 8; c++)
            all_out = all_out & corner_flags[c];
    end

    // ------------------------------------------------------------------
    // Visible tally: restart on the first chunk of a frame, saturate
    // ------------------------------------------------------------------
    logic                        visible_next;
    logic [afc_pkg::TALLY_W-1:0] tally_base;
    logic [afc_pkg::TALLY_W-1:0] tally_next;
    logic [afc_pkg::TALLY_W-1:0] tally_reg;

    assign visible_next = (all_out == '0);
    assign tally_base   = clip_range_reg.first_chunk ? '0 : tally_reg;

    always_comb
    begin
        if (visible_next && (tally_base < afc_pkg::TALLY_W'(afc_pkg::MAX_CHUNKS)))
            tally_next = tally_base + afc_pkg::TALLY_W'(1);
        else
            tally_next = tally_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tally_reg <= '0;
        else if (out_adv && clip_vld_reg)
            tally_reg <= tally_next;
    end

    // ------------------------------------------------------------------
    // Result register: hold until the downstream transfer
    // ------------------------------------------------------------------
    afc_pkg::cull_t out_reg;

    always_ff @(posedge clk)
    begin
        if (out_adv && clip_vld_reg)
        begin
            out_reg.visible          <= visible_next;
            out_reg.out_index_start  <= clip_range_reg.index_start;
            out_reg.out_index_count  <= clip_range_reg.index_count;
            out_reg.out_vertex_base  <= clip_range_reg.vertex_base;
            out_reg.out_vertex_count <= clip_range_reg.vertex_count;
            out_reg.visible_total    <= tally_next;
        end
    end

    assign cull_valid = out_vld_reg;
    assign cull       = out_reg;

`ifndef ASSERT_OFF
    // The tally never passes its saturation limit
    a_tally_limit: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= afc_pkg::TALLY_W'(afc_pkg::MAX_CHUNKS))
        else $error("visible tally above limit");

    // A held result always reports the tally as it stands
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cull_valid |-> (cull.visible_total == tally_reg))
        else $error("result total differs from tally");

    // A visible chunk is always counted
    a_visible_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (cull_valid && cull.visible) |-> (cull.visible_total != '0))
        else $error("visible chunk with zero total");

    // A stalled clip-sum stage keeps its item
    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (clip_vld_reg && !out_adv) |=> clip_vld_reg)
        else $error("clip stage item dropped under stall");
`endif

endmodule

// ----- tb/afc_cull_checker.sv -----
// ----------------------------------------------------------------------------
// afc_cull_checker - prediction and comparison for the frustum cull unit
// Watches the box, cull and configuration ports, keeps its own copy of the
// matrix registers and the visible tally, and checks each cull transfer
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module afc_cull_checker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          box_valid,
    input  logic                          box_ready,
    input  afc_pkg::box_t                 box,

    input  logic                          cull_valid,
    input  logic                          cull_ready,
    input  afc_pkg::cull_t                cull,

    input  logic                          cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afc_pkg::ROW_W-1:0]     cfg_data,

    output int                            fail_count,
    output int                            waiting,
    output int                            boxes_seen,
    output int                            drawn_count
);

    logic [afc_pkg::ROW_W-1:0]   shadow_regs [8];
    logic [afc_pkg::TALLY_W-1:0] frame_tally;
    afc_pkg::cull_t              due_culls [$];

    // One clip component: offset plus three products, summed at 64 bits.
    function automatic longint clip_value(input int row_code, input int off_code,
                                          input longint x, input longint y,
                                          input longint z);
        logic signed [afc_pkg::COEF_W-1:0] c0;
        logic signed [afc_pkg::COEF_W-1:0] c1;
        logic signed [afc_pkg::COEF_W-1:0] c2;
        logic signed [afc_pkg::OFF_W-1:0]  o;
        longint                            k0;
        longint                            k1;
        longint                            k2;
        longint                            ko;
        c0 = shadow_regs[row_code][15:0];
        c1 = shadow_regs[row_code][31:16];
        c2 = shadow_regs[row_code][47:32];
        o  = shadow_regs[off_code];
        k0 = c0;
        k1 = c1;
        k2 = c2;
        ko = o;
        return ko + k0 * x + k1 * y + k2 * z;
    endfunction

    // Culled only when all eight corners lie beyond one common plane.
    function automatic logic box_in_view(input afc_pkg::box_t b);
        longint lo [3];
        longint hi [3];
        longint x;
        longint y;
        longint z;
        longint cx;
        longint cy;
        longint cz;
        longint cw;
        int     n_left;
        int     n_right;
        int     n_bottom;
        int     n_top;
        int     n_near;
        int     n_far;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        n_left = 0; n_right = 0; n_bottom = 0; n_top = 0; n_near = 0; n_far = 0;
        for (int i = 0; i < 8; i++)
        begin
            x  = (i & 1) ? hi[0] : lo[0];
            y  = (i & 2) ? hi[1] : lo[1];
            z  = (i & 4) ? hi[2] : lo[2];
            cx = clip_value(afc_pkg::CFG_ROW_X, afc_pkg::CFG_OFF_X, x, y, z);
            cy = clip_value(afc_pkg::CFG_ROW_Y, afc_pkg::CFG_OFF_Y, x, y, z);
            cz = clip_value(afc_pkg::CFG_ROW_Z, afc_pkg::CFG_OFF_Z, x, y, z);
            cw = clip_value(afc_pkg::CFG_ROW_W, afc_pkg::CFG_OFF_W, x, y, z);
            if (cx < -cw) n_left++;
            if (cx > cw)  n_right++;
            if (cy < -cw) n_bottom++;
            if (cy > cw)  n_top++;
            if (cz < 0)   n_near++;
            if (cz > cw)  n_far++;
        end
        return !(n_left == 8 || n_right == 8 || n_bottom == 8 ||
                 n_top == 8 || n_near == 8 || n_far == 8);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        afc_pkg::cull_t want;
        logic           seen;
        if (!rst_n)
        begin
            shadow_regs[afc_pkg::CFG_ROW_X] = afc_pkg::ROW_X_RESET;
            shadow_regs[afc_pkg::CFG_ROW_Y] = afc_pkg::ROW_Y_RESET;
            shadow_regs[afc_pkg::CFG_ROW_Z] = afc_pkg::ROW_Z_RESET;
            shadow_regs[afc_pkg::CFG_ROW_W] = afc_pkg::ROW_W_RESET;
            shadow_regs[afc_pkg::CFG_OFF_X] = afc_pkg::OFF_X_RESET;
            shadow_regs[afc_pkg::CFG_OFF_Y] = afc_pkg::OFF_Y_RESET;
            shadow_regs[afc_pkg::CFG_OFF_Z] = afc_pkg::OFF_Z_RESET;
            shadow_regs[afc_pkg::CFG_OFF_W] = afc_pkg::OFF_W_RESET;
            frame_tally = '0;
            due_culls.delete();
            fail_count  = 0;
            waiting     = 0;
            boxes_seen  = 0;
            drawn_count = 0;
        end
        else
        begin
            if (box_valid && box_ready)
            begin
                seen = box_in_view(box);
                if (box.first_chunk)
                    frame_tally = '0;
                if (seen && frame_tally < afc_pkg::MAX_CHUNKS)
                    frame_tally = frame_tally + 1'b1;
                want.visible          = seen;
                want.out_index_start  = box.index_start;
                want.out_index_count  = box.index_count;
                want.out_vertex_base  = box.vertex_base;
                want.out_vertex_count = box.vertex_count;
                want.visible_total    = frame_tally;
                due_culls = {due_culls, want};
                boxes_seen++;
            end
            if (cull_valid && cull_ready)
            begin
                if (due_culls.size() == 0)
                begin
                    $error("cull transfer with no result outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_culls.pop_front();
                    check_field("visible", want.visible, cull.visible);
                    check_field("out_index_start", want.out_index_start,
                                cull.out_index_start);
                    check_field("out_index_count", want.out_index_count,
                                cull.out_index_count);
                    check_field("out_vertex_base", want.out_vertex_base,
                                cull.out_vertex_base);
                    check_field("out_vertex_count", want.out_vertex_count,
                                cull.out_vertex_count);
                    check_field("visible_total", want.visible_total,
                                cull.visible_total);
                    if (want.visible)
                        drawn_count++;
                end
            end
            if (cfg_we)
                shadow_regs[cfg_index] = cfg_data;
            waiting = due_culls.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the AABB frustum cull unit
// Drives chunk boxes through a set of matrix settings, from the identity
// transform to all-zero, all-one and extreme rows, with random idling on
// both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    // Kinds of matrix setting visited by the random part
    typedef enum int {
        SET_IDENTITY,
        SET_PLAUSIBLE,
        SET_ZERO,
        SET_TOP,
        SET_ONES,
        SET_RANDOM
    } setting_t;

    localparam int BOXES_PER_SETTING = 160;
    localparam int LONG_FRAME_BOXES  = 380;
    localparam int SETTLE_CYCLES     = 8;       // pipeline is four deep
    localparam int LIMIT_CYCLES      = 400000;

    // Q.8: one metre is 256; under the identity transform the frustum is
    // |x| <= 1 m, |y| <= 1 m, 0 <= z <= 1 m.
    localparam int ONE_M = 256;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          box_valid  = 1'b0;
    logic                          box_ready;
    afc_pkg::box_t                 box        = '0;
    logic                          cull_valid;
    logic                          cull_ready = 1'b0;
    afc_pkg::cull_t                cull;
    logic                          cfg_we     = 1'b0;
    logic [afc_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [afc_pkg::ROW_W-1:0]     cfg_data   = '0;

    int                            fail_count;
    int                            waiting;
    int                            boxes_seen;
    int                            drawn_count;
    int                            cycles     = 0;
    logic                          quiet      = 1'b0;   // no idling on either side
    logic [afc_pkg::ROW_W-1:0]     set_regs [8];
    int                            settings_used = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    aabb_frustum_cull_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box),
        .cull_valid (cull_valid),
        .cull_ready (cull_ready),
        .cull       (cull),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    afc_cull_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_ready   (box_ready),
        .box         (box),
        .cull_valid  (cull_valid),
        .cull_ready  (cull_ready),
        .cull        (cull),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .waiting     (waiting),
        .boxes_seen  (boxes_seen),
        .drawn_count (drawn_count)
    );

    // Receiver: stall about a third of the cycles, unless in a quiet stretch.
    always @(negedge clk)
        cull_ready <= quiet || ($urandom_range(0, 99) >= 33);

    // Pack three Q4.12 coefficients; the x coefficient sits in the low bits.
    function automatic logic [afc_pkg::ROW_W-1:0] pack_row(input int cx, input int cy,
                                                           input int cz);
        return {cz[15:0], cy[15:0], cx[15:0]};
    endfunction

    function automatic logic [afc_pkg::ROW_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Box with the given corners and a random draw range.
    function automatic afc_pkg::box_t make_box(input int nx, input int ny, input int nz,
                                               input int xx, input int xy, input int xz,
                                               input logic first);
        afc_pkg::box_t b;
        b.min_x        = afc_pkg::COORD_W'(nx);
        b.min_y        = afc_pkg::COORD_W'(ny);
        b.min_z        = afc_pkg::COORD_W'(nz);
        b.max_x        = afc_pkg::COORD_W'(xx);
        b.max_y        = afc_pkg::COORD_W'(xy);
        b.max_z        = afc_pkg::COORD_W'(xz);
        b.index_start  = $urandom;
        b.index_count  = $urandom;
        b.vertex_base  = $urandom;
        b.vertex_count = $urandom;
        b.first_chunk  = first;
        return b;
    endfunction

    // Mostly ordered boxes around the frustum, some inverted, some with
    // corners anywhere in the 24-bit range.
    function automatic afc_pkg::box_t random_box();
        int   lo [3];
        int   hi [3];
        int   pick;
        logic first;
        pick  = $urandom_range(0, 99);
        first = ($urandom_range(0, 99) < 4);
        for (int a = 0; a < 3; a++)
        begin
            if (pick < 60)
            begin
                lo[a] = int'($urandom_range(0, 6 * ONE_M)) - 3 * ONE_M;
                hi[a] = lo[a] + int'($urandom_range(0, 2 * ONE_M));
            end
            else if (pick < 70)
            begin
                hi[a] = int'($urandom_range(0, 6 * ONE_M)) - 3 * ONE_M;
                lo[a] = hi[a] + 1 + int'($urandom_range(0, 2 * ONE_M));
            end
            else
            begin
                lo[a] = int'($urandom);
                hi[a] = int'($urandom);
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], first);
    endfunction

    // Present one box at a falling edge, idling first at random, and hold
    // it until the transfer; return at the following falling edge.
    task automatic send_box(input afc_pkg::box_t b);
        while (!quiet && $urandom_range(0, 99) < 33)
        begin
            box_valid <= 1'b0;
            @(negedge clk);
        end
        box       <= b;
        box_valid <= 1'b1;
        do
            @(posedge clk);
        while (!box_ready);
        @(negedge clk);
    endtask

    // Let every outstanding result arrive, then let the pipeline settle.
    task automatic drain();
        box_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all eight registers from set_regs, one per cycle.
    task automatic load_setting();
        for (int k = afc_pkg::CFG_ROW_X; k <= afc_pkg::CFG_OFF_W; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= k[afc_pkg::CFG_IDX_W-1:0];
            cfg_data  <= set_regs[k];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic choose_setting(input setting_t kind);
        case (kind)
            SET_IDENTITY:
            begin
                set_regs[afc_pkg::CFG_ROW_X] = afc_pkg::ROW_X_RESET;
                set_regs[afc_pkg::CFG_ROW_Y] = afc_pkg::ROW_Y_RESET;
                set_regs[afc_pkg::CFG_ROW_Z] = afc_pkg::ROW_Z_RESET;
                set_regs[afc_pkg::CFG_ROW_W] = afc_pkg::ROW_W_RESET;
                set_regs[afc_pkg::CFG_OFF_X] = afc_pkg::OFF_X_RESET;
                set_regs[afc_pkg::CFG_OFF_Y] = afc_pkg::OFF_Y_RESET;
                set_regs[afc_pkg::CFG_OFF_Z] = afc_pkg::OFF_Z_RESET;
                set_regs[afc_pkg::CFG_OFF_W] = afc_pkg::OFF_W_RESET;
            end
            SET_PLAUSIBLE:
            begin
                // Moderate coefficients and a positive w so that results mix
                for (int k = afc_pkg::CFG_ROW_X; k <= afc_pkg::CFG_ROW_Z; k++)
                    set_regs[k] = pack_row(int'($urandom_range(0, 16383)) - 8192,
                                           int'($urandom_range(0, 16383)) - 8192,
                                           int'($urandom_range(0, 16383)) - 8192);
                set_regs[afc_pkg::CFG_ROW_W] =
                    pack_row(int'($urandom_range(0, 2047)) - 1024,
                             int'($urandom_range(0, 2047)) - 1024,
                             int'($urandom_range(0, 2047)) - 1024);
                for (int k = afc_pkg::CFG_OFF_X; k <= afc_pkg::CFG_OFF_Z; k++)
                    set_regs[k] = afc_pkg::ROW_W'(int'($urandom_range(0, 1 << 23))
                                                  - (1 << 22));
                set_regs[afc_pkg::CFG_OFF_W] =
                    afc_pkg::ROW_W'($urandom_range(1 << 19, 1 << 22));
            end
            SET_ZERO:
            begin
                for (int k = afc_pkg::CFG_ROW_X; k <= afc_pkg::CFG_OFF_W; k++)
                    set_regs[k] = '0;
            end
            SET_TOP:
            begin
                // Largest coefficients of both signs, offsets at the limits
                set_regs[afc_pkg::CFG_ROW_X] = 48'h7FFF_7FFF_7FFF;
                set_regs[afc_pkg::CFG_ROW_Y] = 48'h8000_8000_8000;
                set_regs[afc_pkg::CFG_ROW_Z] = 48'h7FFF_8000_7FFF;
                set_regs[afc_pkg::CFG_ROW_W] = 48'h8000_7FFF_8000;
                set_regs[afc_pkg::CFG_OFF_X] = 48'h7FFF_FFFF_FFFF;
                set_regs[afc_pkg::CFG_OFF_Y] = 48'h8000_0000_0000;
                set_regs[afc_pkg::CFG_OFF_Z] = 48'h7FFF_FFFF_FFFF;
                set_regs[afc_pkg::CFG_OFF_W] = 48'h7FFF_FFFF_FFFF;
            end
            SET_ONES:
            begin
                for (int k = afc_pkg::CFG_ROW_X; k <= afc_pkg::CFG_OFF_W; k++)
                    set_regs[k] = 48'hFFFF_FFFF_FFFF;
            end
            default:
            begin
                for (int k = afc_pkg::CFG_ROW_X; k <= afc_pkg::CFG_OFF_W; k++)
                    set_regs[k] = rand48();
            end
        endcase
    endtask

    // Watchdog: give up well past the slowest correct run.
    initial
    begin
        while (cycles < LIMIT_CYCLES)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        afc_pkg::box_t b;

        // Hold reset, then release it at a falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ------------------------------------------------------------------
        // Directed part under the identity transform
        // ------------------------------------------------------------------
        choose_setting(SET_IDENTITY);
        load_setting();

        // Inside, then fully beyond each of the six planes
        send_box(make_box(-128, -128, 0, 128, 128, 128, 1'b1));
        send_box(make_box(300, -128, 0, 600, 128, 128, 1'b0));
        send_box(make_box(-600, -128, 0, -300, 128, 128, 1'b0));
        send_box(make_box(-128, 300, 0, 128, 600, 128, 1'b0));
        send_box(make_box(-128, -600, 0, 128, -300, 128, 1'b0));
        send_box(make_box(-128, -128, -600, 128, 128, -10, 1'b0));
        send_box(make_box(-128, -128, 300, 128, 128, 600, 1'b0));

        // Flat boxes lying exactly on a plane count as inside
        send_box(make_box(ONE_M, 0, 128, ONE_M, 0, 128, 1'b0));
        send_box(make_box(-ONE_M, 0, 128, -ONE_M, 0, 128, 1'b0));
        send_box(make_box(0, ONE_M, 128, 0, ONE_M, 128, 1'b0));
        send_box(make_box(0, -ONE_M, 128, 0, -ONE_M, 128, 1'b0));
        send_box(make_box(0, 0, 0, 0, 0, 0, 1'b0));
        send_box(make_box(0, 0, ONE_M, 0, 0, ONE_M, 1'b0));
        // One step past the right plane
        send_box(make_box(ONE_M + 1, 0, 128, 300, 0, 128, 1'b0));

        // Enclosing box, and corners split between left and right planes
        send_box(make_box(-600, -600, -600, 600, 600, 600, 1'b0));
        send_box(make_box(-600, -600, 64, 600, 600, 64, 1'b0));

        // Inverted boxes: corners taken as given
        send_box(make_box(600, 600, 200, -600, -600, -10, 1'b0));
        send_box(make_box(600, -128, 0, 300, 128, 128, 1'b0));

        // Coordinate extremes
        send_box(make_box(8388607, 8388607, 8388607,
                          8388607, 8388607, 8388607, 1'b0));
        send_box(make_box(-8388608, -8388608, -8388608,
                          -8388608, -8388608, -8388608, 1'b0));
        send_box(make_box(-8388608, -8388608, -8388608,
                          8388607, 8388607, 8388607, 1'b0));

        // Draw range extremes; a culled first chunk leaves the tally at zero
        b = make_box(300, -128, 0, 600, 128, 128, 1'b1);
        b.index_start  = '0;
        b.index_count  = '0;
        b.vertex_base  = '0;
        b.vertex_count = '0;
        send_box(b);
        b = make_box(-128, -128, 0, 128, 128, 128, 1'b0);
        b.index_start  = '1;
        b.index_count  = '1;
        b.vertex_base  = '1;
        b.vertex_count = '1;
        send_box(b);

        // ------------------------------------------------------------------
        // Random part: one batch of boxes per matrix setting
        // ------------------------------------------------------------------
        for (int s = SET_IDENTITY; s <= SET_RANDOM; s++)
        begin
            drain();
            choose_setting(setting_t'(s));
            load_setting();
            // Run the plausible setting flat out on both sides
            quiet <= (setting_t'(s) == SET_PLAUSIBLE);
            for (int n = 0; n < BOXES_PER_SETTING; n++)
                send_box(random_box());
            quiet <= 1'b0;
        end

        // A second fully random setting after the extremes
        drain();
        choose_setting(SET_RANDOM);
        load_setting();
        for (int n = 0; n < BOXES_PER_SETTING / 2; n++)
            send_box(random_box());

        // ------------------------------------------------------------------
        // Long frame of visible chunks, then a run of restarts
        // ------------------------------------------------------------------
        drain();
        choose_setting(SET_IDENTITY);
        load_setting();
        send_box(make_box(-128, -128, 0, 128, 128, 128, 1'b1));
        for (int n = 0; n < LONG_FRAME_BOXES; n++)
            send_box(make_box(int'($urandom_range(0, 128)) - 128,
                              int'($urandom_range(0, 128)) - 128,
                              int'($urandom_range(0, 64)),
                              int'($urandom_range(0, 128)),
                              int'($urandom_range(0, 128)),
                              int'($urandom_range(64, 128)), 1'b0));
        for (int n = 0; n < 4; n++)
            send_box(make_box(-128, -128, 0, 128, 128, 128, 1'b1));

        // Drop valid and wait out every outstanding result
        drain();

        $display("tb: %0d boxes checked over %0d matrix settings, %0d drawn",
                 boxes_seen, settings_used, drawn_count);
        $display("tb: covered plane edges, inverted boxes, range extremes and long frames");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
sv/afc_pkg.sv
sv/afc_plane_test.sv
sv/aabb_frustum_cull_unit.sv
tb/afc_cull_checker.sv
tb/testbench.sv
